### sv/chbt_pkg.sv
`timescale 1ns / 1ps
package chbt_pkg;

   localparam int DEF_MAX_CHARS      = 256;
   localparam int DEF_MAX_PARAGRAPHS = 32;
   localparam int DEF_COORD_BITS     = 16;

   localparam logic [7:0] TOL_RESET    = 8'd4;
   localparam logic [2:0] CSR_TOL_ADDR = 3'd0;
   localparam logic [2:0] DRAIN_CYCLES = 3'd6;

   localparam logic [1:0] REQ_CLEAR     = 2'd0;
   localparam logic [1:0] REQ_LOAD_PARA = 2'd1;
   localparam logic [1:0] REQ_LOAD_CHAR = 2'd2;
   localparam logic [1:0] REQ_QUERY     = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] box_left;
      logic [15:0] box_top;
      logic [15:0] box_right;
      logic [15:0] box_bottom;
      logic        is_vertical;
      logic        starts_line;
      logic [15:0] point_x;
      logic [15:0] point_y;
   } req_data_type;

   typedef struct packed {
      logic       found;
      logic [4:0] paragraph_index;
      logic [7:0] char_index;
   } rsp_data_type;

   typedef struct packed {
      logic clear;
      logic load_para;
      logic load_char;
      logic start;
      logic issue;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic char_empty;
   } stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

### sv/chbt_ctrl.sv
`timescale 1ns / 1ps
module chbt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_type,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  chbt_pkg::stat_type stat,
   output chbt_pkg::cmd_type  cmd
);
   import chbt_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] drain_ff, drain_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_type == REQ_QUERY) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.char_empty || stat.addr_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_CYCLES - 3'd1) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      accept        = req_valid && state_ff == ST_IDLE;
      req_stall     = state_ff != ST_IDLE;
      cmd.clear     = accept && req_type == REQ_CLEAR;
      cmd.load_para = accept && req_type == REQ_LOAD_PARA;
      cmd.load_char = accept && req_type == REQ_LOAD_CHAR;
      cmd.start     = accept && req_type == REQ_QUERY;
      cmd.issue     = state_ff == ST_SCAN && !stat.char_empty;
      cmd.capture   = state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall);
      drain_in      = (state_ff == ST_DRAIN) ? drain_ff + 3'd1 : 3'd0;
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_valid = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/chbt_datapath.sv
`timescale 1ns / 1ps
module chbt_datapath #(
   parameter int MAX_CHARS      = chbt_pkg::DEF_MAX_CHARS,
   parameter int MAX_PARAGRAPHS = chbt_pkg::DEF_MAX_PARAGRAPHS,
   parameter int COORD_BITS     = chbt_pkg::DEF_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  chbt_pkg::cmd_type      cmd,
   input  chbt_pkg::req_data_type req_data,
   input  logic [7:0]             tolerance,
   output chbt_pkg::stat_type     stat,
   output chbt_pkg::rsp_data_type rsp_data
);
   import chbt_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int W   = COORD_BITS + 2;
   localparam int CIW = $clog2(MAX_CHARS);
   localparam int PIW = (MAX_PARAGRAPHS > 1) ? $clog2(MAX_PARAGRAPHS) : 1;
   localparam int BW  = 4 * COORD_BITS;
   localparam int DW  = 2 * COORD_BITS + 1;

   logic [BW-1:0]  cbox_mem  [MAX_CHARS];
   logic [PIW-1:0] cpar_mem  [MAX_CHARS];
   logic           cls_mem   [MAX_CHARS];
   logic [BW-1:0]  pbox_mem  [MAX_PARAGRAPHS];
   logic           pvert_mem [MAX_PARAGRAPHS];
   logic [CIW:0]   pfirst_mem[MAX_PARAGRAPHS];

   logic [CIW:0]   char_count_ff;
   logic [PIW:0]   para_count_ff;
   logic [CIW-1:0] addr_ff;
   logic           char_full, para_full;
   logic [BW-1:0]  load_box;
   logic [39:0]    ext_l, ext_t, ext_r, ext_b, ext_x, ext_y;
   logic [C-1:0]   pt_x_ff, pt_y_ff;

   logic           q_v_ff, n_v_ff, c_v_ff, p_v_ff;
   logic [BW-1:0]  q_box_ff, n_box_ff, c_box_ff, p_box_ff;
   logic [PIW-1:0] q_par_ff, n_par_ff, c_par_ff, p_par_ff;
   logic           q_ls_ff, n_ls_ff, c_ls_ff;
   logic [CIW-1:0] q_idx_ff, n_idx_ff, c_idx_ff;
   logic [BW-1:0]  pq_box_ff, c_pbox_ff;
   logic           pq_vert_ff, c_pvert_ff;
   logic [CIW:0]   pq_first_ff, c_pfirst_ff;

   logic           e1_v_ff, e1_hit_ff, e1_hit_in;
   logic [C-1:0]   e1_dx_ff, e1_dy_ff, e1_dx_in, e1_dy_in;
   logic [PIW-1:0] e1_par_ff;
   logic [CIW:0]   e1_ci_ff;
   logic           e2_v_ff, e2_hit_ff;
   logic [DW-1:0]  e2_d_ff;
   logic [PIW-1:0] e2_par_ff;
   logic [CIW:0]   e2_ci_ff;

   logic           hf_ff, nf_ff;
   logic [PIW-1:0] h_par_ff, n_bpar_ff;
   logic [CIW:0]   h_ci_ff, n_bci_ff;
   logic [DW-1:0]  best_ff;
   logic [DW-1:0]  tol_sq;

   logic signed [W-1:0] cl, ct, cr, cb, px, py, wl, wt, wr, wb;
   logic signed [W-1:0] pr_p1, pb_p1, nl_m1, nt_m1;
   logic           prev_ok, next_ok, para_holds;
   logic [PIW+4:0] par_ext;
   logic [CIW+8:0] ci_ext;
   logic [PIW-1:0] out_par;
   logic [CIW:0]   out_ci;

   function automatic logic [C-1:0] gap(input logic [C-1:0] lo, input logic [C-1:0] hi,
                                        input logic [C-1:0] v);
      logic [C-1:0] a, b;
      a = (lo > v) ? lo - v : '0;
      b = (v > hi) ? v - hi : '0;
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [W-1:0] sx(input logic [C-1:0] v);
      return signed'({2'b00, v});
   endfunction

   always_comb begin
      ext_l     = {24'd0, req_data.box_left};
      ext_t     = {24'd0, req_data.box_top};
      ext_r     = {24'd0, req_data.box_right};
      ext_b     = {24'd0, req_data.box_bottom};
      ext_x     = {24'd0, req_data.point_x};
      ext_y     = {24'd0, req_data.point_y};
      load_box  = {ext_l[C-1:0], ext_t[C-1:0], ext_r[C-1:0], ext_b[C-1:0]};
      char_full = char_count_ff == (CIW+1)'(MAX_CHARS);
      para_full = para_count_ff == (PIW+1)'(MAX_PARAGRAPHS);
      stat.char_empty = char_count_ff == '0;
      stat.addr_last  = {1'b0, addr_ff} == char_count_ff - (CIW+1)'(1);
      tol_sq = DW'(tolerance) * DW'(tolerance);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char && !char_full && para_count_ff != '0) begin
         cbox_mem[char_count_ff[CIW-1:0]] <= load_box;
         cpar_mem[char_count_ff[CIW-1:0]] <= PIW'(para_count_ff - (PIW+1)'(1));
         cls_mem[char_count_ff[CIW-1:0]]  <= req_data.starts_line;
      end
      q_box_ff <= cbox_mem[addr_ff];
      q_par_ff <= cpar_mem[addr_ff];
      q_ls_ff  <= cls_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_para && !para_full) begin
         pbox_mem[para_count_ff[PIW-1:0]]   <= load_box;
         pvert_mem[para_count_ff[PIW-1:0]]  <= req_data.is_vertical;
         pfirst_mem[para_count_ff[PIW-1:0]] <= char_count_ff;
      end
      pq_box_ff   <= pbox_mem[q_par_ff];
      pq_vert_ff  <= pvert_mem[q_par_ff];
      pq_first_ff <= pfirst_mem[q_par_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         para_count_ff <= '0;
      end else if (cmd.clear) begin
         char_count_ff <= '0;
         para_count_ff <= '0;
      end else begin
         if (cmd.load_para && !para_full) para_count_ff <= para_count_ff + (PIW+1)'(1);
         if (cmd.load_char && !char_full && para_count_ff != '0) begin
            char_count_ff <= char_count_ff + (CIW+1)'(1);
         end
      end
   end

   always_comb begin
      cl = sx(c_box_ff[4*C-1:3*C]);
      ct = sx(c_box_ff[3*C-1:2*C]);
      cr = sx(c_box_ff[2*C-1:C]);
      cb = sx(c_box_ff[C-1:0]);
      px = sx(pt_x_ff);
      py = sx(pt_y_ff);
      pr_p1 = sx(p_box_ff[2*C-1:C]) + W'(1);
      pb_p1 = sx(p_box_ff[C-1:0]) + W'(1);
      nl_m1 = sx(n_box_ff[4*C-1:3*C]) - W'(1);
      nt_m1 = sx(n_box_ff[3*C-1:2*C]) - W'(1);
      prev_ok = p_v_ff && p_par_ff == c_par_ff && !c_ls_ff;
      next_ok = n_v_ff && n_par_ff == c_par_ff && !n_ls_ff;
      wl = cl;
      wt = ct;
      wr = cr;
      wb = cb;
      if (c_pvert_ff) begin
         if (prev_ok && pb_p1 < ct) wt = pb_p1;
         if (next_ok && nt_m1 > cb) wb = nt_m1;
      end else begin
         if (prev_ok && pr_p1 < cl) wl = pr_p1;
         if (next_ok && nl_m1 > cr) wr = nl_m1;
      end
      para_holds = pt_x_ff >= c_pbox_ff[4*C-1:3*C] && pt_x_ff <= c_pbox_ff[2*C-1:C] &&
                   pt_y_ff >= c_pbox_ff[3*C-1:2*C] && pt_y_ff <= c_pbox_ff[C-1:0];
      e1_hit_in = para_holds && px >= wl && px <= wr && py >= wt && py <= wb;
      e1_dx_in  = gap(c_box_ff[4*C-1:3*C], c_box_ff[2*C-1:C], pt_x_ff);
      e1_dy_in  = gap(c_box_ff[3*C-1:2*C], c_box_ff[C-1:0], pt_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         q_v_ff  <= 1'b0;
         n_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
         p_v_ff  <= 1'b0;
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
         hf_ff   <= 1'b0;
         nf_ff   <= 1'b0;
         addr_ff <= '0;
      end else begin
         q_v_ff  <= cmd.issue;
         n_v_ff  <= q_v_ff;
         c_v_ff  <= n_v_ff;
         p_v_ff  <= c_v_ff;
         e1_v_ff <= c_v_ff;
         e2_v_ff <= e1_v_ff;
         if (cmd.issue) addr_ff <= addr_ff + CIW'(1);
         if (e2_v_ff && e2_hit_ff && !hf_ff) hf_ff <= 1'b1;
         if (e2_v_ff && e2_d_ff <= tol_sq && (!nf_ff || e2_d_ff < best_ff)) nf_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pt_x_ff <= ext_x[C-1:0];
         pt_y_ff <= ext_y[C-1:0];
      end
      q_idx_ff    <= addr_ff;
      n_box_ff    <= q_box_ff;
      n_par_ff    <= q_par_ff;
      n_ls_ff     <= q_ls_ff;
      n_idx_ff    <= q_idx_ff;
      c_box_ff    <= n_box_ff;
      c_par_ff    <= n_par_ff;
      c_ls_ff     <= n_ls_ff;
      c_idx_ff    <= n_idx_ff;
      c_pbox_ff   <= pq_box_ff;
      c_pvert_ff  <= pq_vert_ff;
      c_pfirst_ff <= pq_first_ff;
      p_box_ff    <= c_box_ff;
      p_par_ff    <= c_par_ff;
      e1_hit_ff   <= e1_hit_in;
      e1_dx_ff    <= e1_dx_in;
      e1_dy_ff    <= e1_dy_in;
      e1_par_ff   <= c_par_ff;
      e1_ci_ff    <= {1'b0, c_idx_ff} - c_pfirst_ff;
      e2_hit_ff   <= e1_hit_ff;
      e2_d_ff     <= DW'(e1_dx_ff) * DW'(e1_dx_ff) + DW'(e1_dy_ff) * DW'(e1_dy_ff);
      e2_par_ff   <= e1_par_ff;
      e2_ci_ff    <= e1_ci_ff;
      if (e2_v_ff && e2_hit_ff && !hf_ff) begin
         h_par_ff <= e2_par_ff;
         h_ci_ff  <= e2_ci_ff;
      end
      if (e2_v_ff && e2_d_ff <= tol_sq && (!nf_ff || e2_d_ff < best_ff)) begin
         best_ff   <= e2_d_ff;
         n_bpar_ff <= e2_par_ff;
         n_bci_ff  <= e2_ci_ff;
      end
   end

   always_comb begin
      if (hf_ff) begin
         out_par = h_par_ff;
         out_ci  = h_ci_ff;
      end else if (nf_ff) begin
         out_par = n_bpar_ff;
         out_ci  = n_bci_ff;
      end else begin
         out_par = '0;
         out_ci  = '0;
      end
      par_ext = {5'd0, out_par};
      ci_ext  = {8'd0, out_ci};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rsp_data.found           <= hf_ff || nf_ff;
         rsp_data.paragraph_index <= par_ext[4:0];
         rsp_data.char_index      <= ci_ext[7:0];
      end
   end

endmodule

### sv/char_box_hit_test_unit.sv
`timescale 1ns / 1ps
// Character hit tester. Clear, paragraph load and character load transactions are taken
// while the block is idle; a query makes one pass over the character memory at one
// read per cycle, in which containment in the widened boxes and the nearest squared
// distance are tested together. The result waits in an output register, so further
// loads are taken while it is pending.
module char_box_hit_test_unit #(
   parameter int MAX_CHARS      = chbt_pkg::DEF_MAX_CHARS,
   parameter int MAX_PARAGRAPHS = chbt_pkg::DEF_MAX_PARAGRAPHS,
   parameter int COORD_BITS     = chbt_pkg::DEF_COORD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  chbt_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output chbt_pkg::rsp_data_type rsp_data,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import chbt_pkg::*;

   logic [7:0] tol_ff;
   cmd_type    cmd;
   stat_type   stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (psel && penable && pwrite && paddr == CSR_TOL_ADDR) begin
         tol_ff <= pwdata[7:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_TOL_ADDR) ? {24'd0, tol_ff} : 32'd0;

   chbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_data.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   chbt_datapath #(
      .MAX_CHARS      (MAX_CHARS),
      .MAX_PARAGRAPHS (MAX_PARAGRAPHS),
      .COORD_BITS     (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .tolerance (tol_ff),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/chbt_checker.sv
`timescale 1ns / 1ps
module chbt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input chbt_pkg::req_data_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input chbt_pkg::rsp_data_type rsp_data
);
   import chbt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response transaction changed");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type == REQ_QUERY |=> req_stall)
      else $error("query transaction did not occupy the block");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.req_type != REQ_QUERY && !rsp_valid |=> !rsp_valid)
      else $error("load transaction produced a response");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.paragraph_index == 5'd0 &&
                                       rsp_data.char_index == 8'd0)
      else $error("miss response carries nonzero indexes");

endmodule

bind char_box_hit_test_unit chbt_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
